// ===== src/stu_pkg.sv =====
package stu_pkg;

	// Series limits and fixed-point formats
	localparam int MAX_TERMS       = 32;
	localparam int ACC_FRAC_BITS   = 40;
	localparam int ANGLE_FRAC_BITS = 27;
	localparam int OUT_FRAC_BITS   = 30;

	// Payload widths
	localparam int ANGLE_W = 32;
	localparam int SINE_W  = 32;
	localparam int TERMS_W = 7;

	// Register map
	localparam int               PADDR_W        = 2;
	localparam logic [PADDR_W-1:0] ADDR_ACCURACY = 2'd0;
	localparam logic [31:0]      ACCURACY_RESET = 32'd6108539;

	// Largest term magnitude
	localparam logic [62:0] MAG_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_SUM,
		ST_DIV,
		ST_ACC,
		ST_FIN
	} stu_state_t;

endpackage

// ===== src/stu_if.sv =====
// Argument channel
interface stu_arg_if;
	import stu_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] angle;
	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

// Result channel
interface stu_res_if;
	import stu_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [SINE_W-1:0] sine_value;
	logic [TERMS_W-1:0]       terms_used;
	logic                     not_converged;
	modport source (output valid, output sine_value, output terms_used, output not_converged,
		input ready);
	modport sink   (input valid, input sine_value, input terms_used, input not_converged,
		output ready);
endinterface

// ===== src/sine_taylor_series_unit.sv =====
// Fixed-point sine by the Maclaurin series.
// arg (valid/ready) takes one angle in signed Q5.27, |x| < 16, no range reduction.
// res (valid/ready) returns the sum in signed Q2.30 (saturated), the number of terms
// added and a flag set when the term limit was hit before the accuracy threshold.
// The APB port holds one register, accuracy, at byte address 0: a term whose magnitude
// falls below it ends the series. Write it only while the block is idle.
// Each added term runs on one 32x32 multiplier (two passes of low half, high half and
// combine) followed by a radix-256 divider by (2i)(2i+1), one accumulate step and one
// threshold check.
// One angle is processed at a time; arg.ready is high only while the sequencer is idle,
// so the next angle can be taken in the cycle after the result is loaded.
// The result sits in an output register, so a new angle is taken while it waits; a
// stalled receiver holds a finished result and the sequencer waits in its last state.
// Reset (arst_n low) returns accuracy to 6108539 (about 1e-6/0.18 in 2^-40 units),
// drops any work in flight and clears res.valid.
module sine_taylor_series_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stu_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	stu_arg_if.sink                     arg,
	stu_res_if.source                   res
);
	import stu_pkg::*;

	localparam int I_W      = $clog2(MAX_TERMS);
	localparam int D_W      = $clog2((2*(MAX_TERMS-1))*(2*(MAX_TERMS-1)+1)+1);
	localparam int SH_L     = (ACC_FRAC_BITS >= ANGLE_FRAC_BITS) ?
		ACC_FRAC_BITS - ANGLE_FRAC_BITS : 0;
	localparam int SH_R     = (ACC_FRAC_BITS >= ANGLE_FRAC_BITS) ?
		0 : ANGLE_FRAC_BITS - ACC_FRAC_BITS;
	localparam int OS_R     = (ACC_FRAC_BITS >= OUT_FRAC_BITS) ?
		ACC_FRAC_BITS - OUT_FRAC_BITS : 0;
	localparam int OS_L     = (ACC_FRAC_BITS >= OUT_FRAC_BITS) ?
		0 : OUT_FRAC_BITS - ACC_FRAC_BITS;
	localparam int DIV_STEPS = 8;
	localparam int DIV_CYC   = 64 / DIV_STEPS;
	localparam int DC_W      = $clog2(DIV_CYC);

	stu_state_t          state_q, state_d;
	logic [31:0]         acc_q;
	logic                out_valid_q;
	logic [TERMS_W-1:0]  terms_q;
	logic                nc_q;
	logic [DC_W-1:0]     dcnt_q;

	logic [31:0]         xmag_q;
	logic                neg_q;
	logic [62:0]         mag_q;
	logic [63:0]         sum_q;
	logic                pass_q;
	logic [63:0]         plo_q, phi_q;
	logic [D_W-1:0]      d_q, rem_q;
	logic [63:0]         div_q;

	logic [SINE_W-1:0]   sine_q;
	logic [TERMS_W-1:0]  terms_out_q;
	logic                nc_out_q;

	logic                wr_en;
	logic                in_fire;
	logic                fin_load;
	logic                above_acc;
	logic                at_limit;

	logic [31:0]         a_mag;
	logic [62:0]         mag0;
	logic [63:0]         sum0;

	logic [31:0]         mul_a;
	logic [63:0]         mul_p;
	logic [95:0]         mul_full;
	logic [62:0]         mag_mul;

	logic [I_W:0]        two_i, two_i1;
	logic [2*I_W+1:0]    d_full;
	logic [D_W-1:0]      d_next;

	logic [63:0]         div_nx;
	logic [D_W-1:0]      rem_nx;

	logic [64:0]         addend, s65;
	logic [63:0]         sum_acc;

	logic [63:0]         um, um_c, um_s, um_lim;
	logic [SINE_W-1:0]   sine_nx;

	// Configuration port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign prdata = (paddr == ADDR_ACCURACY) ? acc_q : '0;

	// Argument magnitude and first term
	assign a_mag = arg.angle[ANGLE_W-1] ? 32'(32'd0 - $unsigned(arg.angle))
		: $unsigned(arg.angle);
	assign mag0  = (63'(a_mag) << SH_L) >> SH_R;
	assign sum0  = arg.angle[ANGLE_W-1] ? 64'd0 - {1'b0, mag0} : {1'b0, mag0};

	// Threshold test
	assign above_acc = mag_q >= {31'd0, acc_q};
	assign at_limit  = terms_q >= TERMS_W'(MAX_TERMS);

	// Shared multiplier: term times |x| over two halves, then >> 27 with saturation
	assign mul_a    = (state_q == ST_MUL_HI) ? {1'b0, mag_q[62:32]} : mag_q[31:0];
	assign mul_p    = mul_a * xmag_q;
	assign mul_full = {phi_q, 32'd0} + {32'd0, plo_q};
	assign mag_mul  = (|mul_full[95:90]) ? MAG_MAX : mul_full[89:27];

	// Divisor (2i)(2i+1)
	assign two_i  = {terms_q[I_W-1:0], 1'b0};
	assign two_i1 = {terms_q[I_W-1:0], 1'b1};
	assign d_full = two_i * two_i1;
	assign d_next = D_W'(d_full);

	// Divider: eight restoring steps a cycle on a narrow remainder
	always_comb begin
		logic [63:0]    dv;
		logic [D_W-1:0] rm;
		logic [D_W:0]   trial;
		dv = div_q;
		rm = rem_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {rm, dv[63]};
			dv    = {dv[62:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				rm    = D_W'(trial - {1'b0, d_q});
				dv[0] = 1'b1;
			end else begin
				rm = trial[D_W-1:0];
			end
		end
		div_nx = dv;
		rem_nx = rm;
	end

	// Saturating accumulate with the sign flipped
	assign addend  = neg_q ? {2'b00, div_q[62:0]} : 65'd0 - {2'b00, div_q[62:0]};
	assign s65     = {sum_q[63], sum_q} + addend;
	assign sum_acc = (s65[64] != s65[63]) ?
		(s65[64] ? {1'b1, 63'd0} : {1'b0, 63'h7FFF_FFFF_FFFF_FFFF}) : s65[63:0];

	// Output scaling to Q2.30 with saturation
	assign um     = sum_q[63] ? 64'd0 - sum_q : sum_q;
	assign um_c   = (OS_L > 0 && um >= 64'h0100_0000_0000_0000) ?
		64'h0100_0000_0000_0000 : um;
	assign um_s   = (um_c << OS_L) >> OS_R;
	assign um_lim = sum_q[63] ?
		((um_s > 64'h8000_0000) ? 64'h8000_0000 : um_s) :
		((um_s > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : um_s);
	assign sine_nx = sum_q[63] ? SINE_W'(64'd0 - um_lim) : um_lim[SINE_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (arg.valid) state_d = ST_CHECK;
			ST_CHECK:   state_d = (above_acc && !at_limit) ? ST_MUL_LO : ST_FIN;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_MUL_SUM;
			ST_MUL_SUM: state_d = pass_q ? ST_DIV : ST_MUL_LO;
			ST_DIV:     if (dcnt_q == DC_W'(DIV_CYC-1)) state_d = ST_ACC;
			ST_ACC:     state_d = ST_CHECK;
			ST_FIN:     if (fin_load) state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		arg.ready = (state_q == ST_IDLE);
		fin_load  = (state_q == ST_FIN) && (!out_valid_q || res.ready);
	end

	assign in_fire = arg.valid && arg.ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= ACCURACY_RESET;
			out_valid_q <= 1'b0;
			terms_q     <= TERMS_W'(1);
			nc_q        <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en && paddr == ADDR_ACCURACY) acc_q <= pwdata;
			if (fin_load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			if (in_fire) begin
				terms_q <= TERMS_W'(1);
				nc_q    <= 1'b0;
			end
			if (state_q == ST_CHECK && above_acc && at_limit) nc_q <= 1'b1;
			if (state_q == ST_ACC) terms_q <= terms_q + TERMS_W'(1);
			if (state_q == ST_MUL_SUM) dcnt_q <= '0;
			if (state_q == ST_DIV) dcnt_q <= dcnt_q + DC_W'(1);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (arg.valid) begin
					xmag_q <= a_mag;
					neg_q  <= arg.angle[ANGLE_W-1];
					mag_q  <= mag0;
					sum_q  <= sum0;
				end
			end
			ST_CHECK: begin
				d_q    <= d_next;
				pass_q <= 1'b0;
			end
			ST_MUL_LO: plo_q <= mul_p;
			ST_MUL_HI: phi_q <= mul_p;
			ST_MUL_SUM: begin
				mag_q  <= mag_mul;
				pass_q <= 1'b1;
				if (pass_q) begin
					div_q <= {1'b0, mag_mul};
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				div_q <= div_nx;
				rem_q <= rem_nx;
			end
			ST_ACC: begin
				mag_q <= div_q[62:0];
				neg_q <= ~neg_q;
				sum_q <= sum_acc;
			end
			ST_FIN: begin
			end
		endcase
		if (fin_load) begin
			sine_q      <= sine_nx;
			terms_out_q <= terms_q;
			nc_out_q    <= nc_q;
		end
	end

	// Result channel
	assign res.valid         = out_valid_q;
	assign res.sine_value    = sine_q;
	assign res.terms_used    = terms_out_q;
	assign res.not_converged = nc_out_q;

	// Term counter stays within the series limit
	a_terms_range: assert property (@(posedge clk) disable iff (!arst_n)
		terms_q >= TERMS_W'(1) && terms_q <= TERMS_W'(MAX_TERMS))
		else $error("term count out of range");

	// Divider remainder stays below the divisor
	a_rem_below_d: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < d_q)
		else $error("divider remainder not below divisor");

	// Non-convergence only at the term limit
	a_nc_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load && nc_q |-> terms_q == TERMS_W'(MAX_TERMS))
		else $error("not_converged without reaching term limit");

	// A new angle starts with one term and a threshold check
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_CHECK && terms_q == TERMS_W'(1))
		else $error("bad start of series");

	// A finished result shows up on the result channel
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> res.valid)
		else $error("finished result not presented");

endmodule
